// ===== hw/rtl/mos_pkg.sv =====
`default_nettype none
package mos_pkg;

	// Widths of the fixed-point quantities that travel through the chain.
	localparam int NUM_LANES = 4;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int CNT_W     = 3;
	localparam int MEAN_W    = 32;
	localparam int VAR_W     = 16;
	localparam int WGT_W     = 16;
	localparam int DIFF_W    = 33;
	localparam int ABS_W     = 32;
	localparam int VSQ_W     = 32;
	localparam int TERM_W    = 34;
	localparam int VTERM_W   = 32;
	localparam int AUG_W     = 32;
	localparam int VAUG_W    = 32;
	localparam int SCORE_W   = 40;
	localparam int SVAR_W    = 36;

	typedef enum logic [1:0] {
		MODE_LINEAR,
		MODE_CHEB,
		MODE_AUG_CHEB,
		MODE_MOD_CHEB
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_REF,
		REG_AUG,
		REG_W_A,
		REG_W_B,
		REG_W_C,
		REG_W_D
	} reg_idx_t;

	typedef enum logic [1:0] {
		SIGN_ZERO,
		SIGN_POS,
		SIGN_NEG
	} sign_t;

	typedef struct packed {
		mode_t                              mode;
		logic signed [MEAN_W-1:0]           ref_point;
		logic [WGT_W-1:0]                   aug_weight;
		logic [NUM_LANES-1:0][WGT_W-1:0]    weight;
	} cfg_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] diff;
		logic [ABS_W-1:0]         abs_diff;
		logic [VSQ_W-1:0]         vsq;
	} lane_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [SVAR_W-1:0]         svar;
		logic [SCORE_W-1:0]        aug_sum;
		logic [SVAR_W-1:0]         vaug_sum;
		logic [CNT_W-1:0]          count;
	} acc_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mos_regs.sv =====
`default_nettype none
module mos_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mos_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [mos_pkg::DATA_W-1:0]  pwdata,
	output logic      [mos_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output mos_pkg::cfg_t                    cfg
);

	mos_pkg::cfg_t     cfg_q;
	mos_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = mos_pkg::reg_idx_t'(paddr[mos_pkg::ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= mos_pkg::MODE_LINEAR;
			cfg_q.ref_point  <= '0;
			cfg_q.aug_weight <= '0;
			for (int i = 0; i < mos_pkg::NUM_LANES; i++) begin
				cfg_q.weight[i] <= mos_pkg::WGT_W'(16384);
			end
		end else if (wr_en) begin
			unique case (idx)
				mos_pkg::REG_MODE: cfg_q.mode       <= mos_pkg::mode_t'(pwdata[1:0]);
				mos_pkg::REG_REF:  cfg_q.ref_point  <= pwdata;
				mos_pkg::REG_AUG:  cfg_q.aug_weight <= pwdata[mos_pkg::WGT_W-1:0];
				mos_pkg::REG_W_A:  cfg_q.weight[0]  <= pwdata[mos_pkg::WGT_W-1:0];
				mos_pkg::REG_W_B:  cfg_q.weight[1]  <= pwdata[mos_pkg::WGT_W-1:0];
				mos_pkg::REG_W_C:  cfg_q.weight[2]  <= pwdata[mos_pkg::WGT_W-1:0];
				mos_pkg::REG_W_D:  cfg_q.weight[3]  <= pwdata[mos_pkg::WGT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mos_pkg::REG_MODE: prdata = mos_pkg::DATA_W'(cfg_q.mode);
			mos_pkg::REG_REF:  prdata = cfg_q.ref_point;
			mos_pkg::REG_AUG:  prdata = mos_pkg::DATA_W'(cfg_q.aug_weight);
			mos_pkg::REG_W_A:  prdata = mos_pkg::DATA_W'(cfg_q.weight[0]);
			mos_pkg::REG_W_B:  prdata = mos_pkg::DATA_W'(cfg_q.weight[1]);
			mos_pkg::REG_W_C:  prdata = mos_pkg::DATA_W'(cfg_q.weight[2]);
			mos_pkg::REG_W_D:  prdata = mos_pkg::DATA_W'(cfg_q.weight[3]);
			default:           prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mos_cell.sv =====
`default_nettype none
module mos_cell #(
	parameter int IDX    = 0,
	parameter int NLANES = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mos_pkg::cfg_t                 cfg,
	input  wire logic                          in_valid,
	input  wire mos_pkg::acc_t                 in_acc,
	input  wire mos_pkg::lane_t [NLANES-1:0]   in_lanes,
	output logic                               out_valid,
	output mos_pkg::acc_t                      out_acc,
	output mos_pkg::lane_t [NLANES-1:0]        out_lanes
);

	localparam logic IS_FIRST = (IDX == 0);
	localparam int   PW_T = mos_pkg::WGT_W + 1 + mos_pkg::DIFF_W;
	localparam int   PW_V = mos_pkg::WGT_W + mos_pkg::VSQ_W;
	localparam int   PW_A = mos_pkg::WGT_W + mos_pkg::ABS_W;

	// First half: the four products of this objective, each floored to Q16.16.
	logic signed [PW_T-1:0]            p_term;
	logic [PW_V-1:0]                   p_vterm;
	logic [PW_A-1:0]                   p_aug;
	logic [PW_V-1:0]                   p_vaug;
	mos_pkg::lane_t                    lane;

	logic signed [mos_pkg::TERM_W-1:0] term_s1;
	logic [mos_pkg::VTERM_W-1:0]       vterm_s1;
	logic [mos_pkg::AUG_W-1:0]         aug_s1;
	logic [mos_pkg::VAUG_W-1:0]        vaug_s1;
	logic                              valid_s1;
	mos_pkg::acc_t                     acc_s1;
	mos_pkg::lane_t [NLANES-1:0]       lanes_s1;

	assign lane = in_lanes[IDX];

	always_comb begin
		p_term  = $signed({1'b0, cfg.weight[IDX]}) * lane.diff;
		p_vterm = cfg.weight[IDX] * lane.vsq;
		p_aug   = cfg.aug_weight * lane.abs_diff;
		p_vaug  = cfg.aug_weight * lane.vsq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		term_s1  <= p_term[PW_T-1:16];
		vterm_s1 <= p_vterm[PW_V-1:16];
		aug_s1   <= p_aug[PW_A-1:16];
		vaug_s1  <= p_vaug[PW_V-1:16];
		acc_s1   <= in_acc;
		lanes_s1 <= in_lanes;
	end

	// Second half: fold this objective into the running result.
	logic                               en;
	logic signed [mos_pkg::SCORE_W-1:0] term_x;
	logic signed [mos_pkg::SCORE_W-1:0] cand;
	logic [mos_pkg::SCORE_W-1:0]        aug_n;
	logic [mos_pkg::SVAR_W-1:0]         vaug_n;
	mos_pkg::acc_t                      acc_n;

	always_comb begin
		en     = (acc_s1.count > mos_pkg::CNT_W'(IDX));
		term_x = mos_pkg::SCORE_W'(term_s1);
		aug_n  = acc_s1.aug_sum + mos_pkg::SCORE_W'(aug_s1);
		vaug_n = acc_s1.vaug_sum + mos_pkg::SVAR_W'(vaug_s1);
		cand   = $signed(aug_n) + term_x;
		acc_n  = acc_s1;
		if (en) begin
			acc_n.aug_sum  = aug_n;
			acc_n.vaug_sum = vaug_n;
			case (cfg.mode)
				mos_pkg::MODE_LINEAR: begin
					acc_n.score = acc_s1.score + term_x;
					acc_n.svar  = acc_s1.svar + mos_pkg::SVAR_W'(vterm_s1);
				end
				mos_pkg::MODE_CHEB, mos_pkg::MODE_AUG_CHEB: begin
					if (IS_FIRST || term_x < acc_s1.score) begin
						acc_n.score = term_x;
						acc_n.svar  = mos_pkg::SVAR_W'(vterm_s1);
					end
				end
				default: begin
					if (IS_FIRST || cand < acc_s1.score) begin
						acc_n.score = cand;
						acc_n.svar  = mos_pkg::SVAR_W'(vterm_s1) + vaug_n;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_acc   <= acc_n;
		out_lanes <= lanes_s1;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mos_final.sv =====
`default_nettype none
module mos_final (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire mos_pkg::mode_t                     mode,
	input  wire logic                               in_valid,
	input  wire mos_pkg::acc_t                      in_acc,
	output logic                                    done,
	output logic signed [mos_pkg::SCORE_W-1:0]      score,
	output logic        [mos_pkg::SVAR_W-1:0]       score_var,
	output logic        [1:0]                       score_sign
);

	logic signed [mos_pkg::SCORE_W-1:0] score_n;
	logic [mos_pkg::SVAR_W-1:0]         svar_n;
	mos_pkg::sign_t                     sign_n;

	// Every sum stays well inside the output ranges, so no clamp is needed.
	always_comb begin
		score_n = in_acc.score;
		svar_n  = in_acc.svar;
		if (in_acc.count != '0 && mode == mos_pkg::MODE_AUG_CHEB) begin
			score_n = in_acc.score + $signed(in_acc.aug_sum);
			svar_n  = in_acc.svar + in_acc.vaug_sum;
		end
		if (score_n == '0) begin
			sign_n = mos_pkg::SIGN_ZERO;
		end else if (score_n[mos_pkg::SCORE_W-1]) begin
			sign_n = mos_pkg::SIGN_NEG;
		end else begin
			sign_n = mos_pkg::SIGN_POS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		score      <= score_n;
		score_var  <= svar_n;
		score_sign <= sign_n;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/multiobjective_scalarisation.sv =====
`default_nettype none
// Weighted-sum or Chebyshev scalarization of up to four objectives. One word
// (four Q16.16 means, four Q8.8 deviation terms, a variance flag and an
// objective count) is taken on every cycle in which start is high; busy never
// rises, so a new word may follow in the very next cycle. The result word
// (score, score_var, score_sign) appears on the result ports for one cycle
// with done high, once the word has passed through every pipeline stage. The
// receiver has no way to stall the block: results must be captured on the
// cycle that done is high. The pipeline is built around the chain of objective
// cells: one input stage forms the deviations and squared variances, each
// cell spends one stage on its four products and one on folding them into
// the running result, and one output stage adds the augmentation and forms
// the sign. Weights, reference point, alpha and mode come over the APB-style
// port and may be changed only while no word is in flight.
module multiobjective_scalarisation #(
	parameter int MAX_OBJECTIVES = 4
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic        [mos_pkg::ADDR_W-1:0]    paddr,
	input  wire logic        [mos_pkg::DATA_W-1:0]    pwdata,
	output logic             [mos_pkg::DATA_W-1:0]    prdata,
	output logic                                      pready,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [mos_pkg::MEAN_W-1:0]    mean_a,
	input  wire logic signed [mos_pkg::MEAN_W-1:0]    mean_b,
	input  wire logic signed [mos_pkg::MEAN_W-1:0]    mean_c,
	input  wire logic signed [mos_pkg::MEAN_W-1:0]    mean_d,
	input  wire logic        [mos_pkg::VAR_W-1:0]     var_a,
	input  wire logic        [mos_pkg::VAR_W-1:0]     var_b,
	input  wire logic        [mos_pkg::VAR_W-1:0]     var_c,
	input  wire logic        [mos_pkg::VAR_W-1:0]     var_d,
	input  wire logic                                 var_present,
	input  wire logic        [mos_pkg::CNT_W-1:0]     objective_count,
	output logic                                      done,
	output logic signed      [mos_pkg::SCORE_W-1:0]   score,
	output logic             [mos_pkg::SVAR_W-1:0]    score_var,
	output logic             [1:0]                    score_sign
);

	localparam int LATENCY = 2 * MAX_OBJECTIVES + 2;

	mos_pkg::cfg_t cfg;

	mos_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Every stage moves on each cycle, so the block is always ready.
	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// Input stage: deviation from the reference, its magnitude, and the
	// squared deviation term (forced to zero when variances are absent).
	logic signed [mos_pkg::MEAN_W-1:0] mean_arr [mos_pkg::NUM_LANES];
	logic        [mos_pkg::VAR_W-1:0]  var_arr  [mos_pkg::NUM_LANES];
	mos_pkg::lane_t [MAX_OBJECTIVES-1:0] lanes_n;
	mos_pkg::lane_t [MAX_OBJECTIVES-1:0] lanes_s0;
	mos_pkg::acc_t                       acc_init;
	mos_pkg::acc_t                       acc_s0;
	logic                                valid_s0;
	logic [mos_pkg::CNT_W-1:0]           count_n;

	assign mean_arr[0] = mean_a;
	assign mean_arr[1] = mean_b;
	assign mean_arr[2] = mean_c;
	assign mean_arr[3] = mean_d;
	assign var_arr[0]  = var_a;
	assign var_arr[1]  = var_b;
	assign var_arr[2]  = var_c;
	assign var_arr[3]  = var_d;

	always_comb begin
		for (int i = 0; i < MAX_OBJECTIVES; i++) begin
			lanes_n[i].diff = {mean_arr[i][mos_pkg::MEAN_W-1], mean_arr[i]}
				- {cfg.ref_point[mos_pkg::MEAN_W-1], cfg.ref_point};
			lanes_n[i].abs_diff = lanes_n[i].diff[mos_pkg::DIFF_W-1]
				? mos_pkg::ABS_W'(-lanes_n[i].diff)
				: lanes_n[i].diff[mos_pkg::ABS_W-1:0];
			lanes_n[i].vsq = var_present ? var_arr[i] * var_arr[i] : '0;
		end
		// A count beyond the number of cells is treated as all of them.
		if (objective_count > mos_pkg::CNT_W'(MAX_OBJECTIVES)) begin
			count_n = mos_pkg::CNT_W'(MAX_OBJECTIVES);
		end else begin
			count_n = objective_count;
		end
		// The running result starts empty and carries only the count.
		acc_init       = '0;
		acc_init.count = count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		lanes_s0 <= lanes_n;
		acc_s0   <= acc_init;
	end

	// The chain of objective cells: cell k consumes lane k and hands the
	// running score and sums to cell k+1.
	logic                                valid_c [MAX_OBJECTIVES+1];
	mos_pkg::acc_t                       acc_c   [MAX_OBJECTIVES+1];
	mos_pkg::lane_t [MAX_OBJECTIVES-1:0] lanes_c [MAX_OBJECTIVES+1];

	assign valid_c[0] = valid_s0;
	assign acc_c[0]   = acc_s0;
	assign lanes_c[0] = lanes_s0;

	for (genvar k = 0; k < MAX_OBJECTIVES; k++) begin : g_cell
		mos_cell #(
			.IDX    (k),
			.NLANES (MAX_OBJECTIVES)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg),
			.in_valid  (valid_c[k]),
			.in_acc    (acc_c[k]),
			.in_lanes  (lanes_c[k]),
			.out_valid (valid_c[k+1]),
			.out_acc   (acc_c[k+1]),
			.out_lanes (lanes_c[k+1])
		);
	end

	mos_final u_final (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (cfg.mode),
		.in_valid   (valid_c[MAX_OBJECTIVES]),
		.in_acc     (acc_c[MAX_OBJECTIVES]),
		.done       (done),
		.score      (score),
		.score_var  (score_var),
		.score_sign (score_sign)
	);

`ifndef SYNTHESIS
	// Every accepted word comes out after the fixed pipeline latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("accepted word produced no result");

	// No result appears without a word accepted the same latency earlier.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a matching accepted word");

	// A word with no objectives gives an all-zero result.
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && objective_count == '0) |-> ##LATENCY
		(score == '0 && score_var == '0 && score_sign == mos_pkg::SIGN_ZERO))
		else $error("empty word gave a nonzero result");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_multiobjective_scalarisation.sv =====
`default_nettype none
// Self-checking bench for the weighted Chebyshev scalarization block.
//
// A queue of jobs is filled up front. Each job is either one input word
// (four means, four deviation terms, the variance flag and the objective
// count) or one register write on the APB-style port. A driver that runs on
// the falling clock edge takes jobs from that queue and spaces them with
// random gaps. A monitor on the rising clock edge watches both handshakes.
// When a word is taken it computes the expected result word from its own copy
// of the register file and queues it. When done is high it compares the
// result word, field by field, with the oldest expected word.
module tb_multiobjective_scalarisation;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_OBJ = 4;
	// The drain wait covers a result word's whole trip through the pipeline,
	// with margin added before the final verdict.
	localparam int DRAIN_CYCLES = 2 * MAX_OBJ + 10;
	// This limit is several times the length of the slowest legal run.
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PHASES = 14;
	localparam int WORDS_PER_PHASE = 100;
	// This address decodes to no register, so a write there must change
	// nothing.
	localparam logic [2:0] REG_NONE = 3'd7;

	localparam longint SCORE_HI = 64'sh0000_007F_FFFF_FFFF;
	localparam longint SCORE_LO = -64'sh0000_0080_0000_0000;
	localparam longint SVAR_HI = 64'sh0000_000F_FFFF_FFFF;

	// One job for the driver. It is either a register write or an input word.
	typedef struct packed {
		logic             is_reg;
		logic [2:0]       idx;
		logic [31:0]      value;
		logic [3:0][31:0] mean;
		logic [3:0][15:0] dev;
		logic             vp;
		logic [2:0]       cnt;
	} job_t;

	typedef struct packed {
		logic signed [mos_pkg::SCORE_W-1:0] score;
		logic [mos_pkg::SVAR_W-1:0]         svar;
		mos_pkg::sign_t                     sign;
	} word_score_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                               psel = 1'b0;
	logic                               penable = 1'b0;
	logic                               pwrite = 1'b1;
	logic [mos_pkg::ADDR_W-1:0]         paddr = '0;
	logic [mos_pkg::DATA_W-1:0]         pwdata = '0;
	logic [mos_pkg::DATA_W-1:0]         prdata;
	logic                               pready;
	logic                               start = 1'b0;
	logic                               busy;
	logic signed [mos_pkg::MEAN_W-1:0]  mean_a = '0;
	logic signed [mos_pkg::MEAN_W-1:0]  mean_b = '0;
	logic signed [mos_pkg::MEAN_W-1:0]  mean_c = '0;
	logic signed [mos_pkg::MEAN_W-1:0]  mean_d = '0;
	logic [mos_pkg::VAR_W-1:0]          var_a = '0;
	logic [mos_pkg::VAR_W-1:0]          var_b = '0;
	logic [mos_pkg::VAR_W-1:0]          var_c = '0;
	logic [mos_pkg::VAR_W-1:0]          var_d = '0;
	logic                               var_present = 1'b0;
	logic [mos_pkg::CNT_W-1:0]          objective_count = '0;
	logic                               done;
	logic signed [mos_pkg::SCORE_W-1:0] score;
	logic [mos_pkg::SVAR_W-1:0]         score_var;
	logic [1:0]                         score_sign;

	multiobjective_scalarisation #(
		.MAX_OBJECTIVES(MAX_OBJ)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.mean_a(mean_a),
		.mean_b(mean_b),
		.mean_c(mean_c),
		.mean_d(mean_d),
		.var_a(var_a),
		.var_b(var_b),
		.var_c(var_c),
		.var_d(var_d),
		.var_present(var_present),
		.objective_count(objective_count),
		.done(done),
		.score(score),
		.score_var(score_var),
		.score_sign(score_sign)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// This bench keeps its own copy of the register file. It is updated at the
	// exact edge at which the block takes a write.
	mos_pkg::mode_t    cfg_mode = mos_pkg::MODE_LINEAR;
	logic [31:0]       cfg_ref = '0;
	logic [15:0]       cfg_alpha = '0;
	logic [3:0][15:0]  cfg_w = {4{16'd16384}};

	job_t        work_list[$];
	word_score_t pending_scores[$];
	job_t        drv_word;
	logic        word_taken = 1'b0;
	logic        reg_taken = 1'b0;
	int          gap_left = 0;
	int          burst_left = 0;
	int          errors = 0;
	int          cycles = 0;

	// This computes the expected result word for one input word under the
	// current registers. Each product is truncated toward minus infinity to
	// Q16.16 on its own, and the truncated values are then summed.
	function automatic word_score_t scalarize_word(job_t j);
		word_score_t r;
		longint d, ad, vsq, term, vterm, asum, vasum, best, vbest;
		int n, k;
		n = (j.cnt > MAX_OBJ) ? MAX_OBJ : int'(j.cnt);
		best = 0;
		vbest = 0;
		asum = 0;
		vasum = 0;
		for (k = 0; k < n; k++) begin
			d = longint'($signed(j.mean[k])) - longint'($signed(cfg_ref));
			ad = (d < 0) ? -d : d;
			vsq = j.vp ? longint'(j.dev[k]) * longint'(j.dev[k]) : 64'sd0;
			term = (longint'(cfg_w[k]) * d) >>> 16;
			vterm = (longint'(cfg_w[k]) * vsq) >>> 16;
			// The augmentation sums run ahead of the comparison. Modified
			// Chebyshev therefore sees the sum up to and including this
			// objective.
			asum += (longint'(cfg_alpha) * ad) >>> 16;
			vasum += (longint'(cfg_alpha) * vsq) >>> 16;
			case (cfg_mode)
				mos_pkg::MODE_LINEAR: begin
					best += term;
					vbest += vterm;
				end
				mos_pkg::MODE_CHEB, mos_pkg::MODE_AUG_CHEB: begin
					// On a tie the first objective that reached the minimum
					// keeps its variance.
					if (k == 0 || term < best) begin
						best = term;
						vbest = vterm;
					end
				end
				default: begin
					if (k == 0 || term + asum < best) begin
						best = term + asum;
						vbest = vterm + vasum;
					end
				end
			endcase
		end
		// With no objectives the result stays zero, even in augmented mode.
		if (n > 0 && cfg_mode == mos_pkg::MODE_AUG_CHEB) begin
			best += asum;
			vbest += vasum;
		end
		if (best > SCORE_HI) best = SCORE_HI;
		if (best < SCORE_LO) best = SCORE_LO;
		if (vbest > SVAR_HI) vbest = SVAR_HI;
		r.score = best[mos_pkg::SCORE_W-1:0];
		r.svar = vbest[mos_pkg::SVAR_W-1:0];
		r.sign = (best == 0) ? mos_pkg::SIGN_ZERO
			: ((best > 0) ? mos_pkg::SIGN_POS : mos_pkg::SIGN_NEG);
		return r;
	endfunction

	// Gaps between jobs are mostly short and a few are long. Now and then
	// a burst of back-to-back words is started.
	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(30, 100);
	endfunction

	// The driver changes inputs on the falling edge. Each handshake signal
	// gets its next value worked out first and is then assigned once, so a
	// word that follows at once keeps start high without a glitch.
	always @(negedge clk) begin : feed_jobs
		logic nx_start, nx_sel, nx_en;
		job_t j;
		nx_start = start;
		nx_sel = psel;
		nx_en = penable;
		if (arst_n) begin
			if (word_taken) nx_start = 1'b0;
			if (reg_taken) begin
				nx_sel = 1'b0;
				nx_en = 1'b0;
			end else if (psel) begin
				nx_en = 1'b1;
			end
			if (!nx_start && !nx_sel) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (work_list.size() > 0) begin
					j = work_list[0];
					if (j.is_reg) begin
						// Registers may change only while no word is in flight.
						// Each word yields exactly one result, so an empty
						// expectation queue means that the block is idle.
						if (pending_scores.size() == 0) begin
							void'(work_list.pop_front());
							nx_sel = 1'b1;
							nx_en = 1'b0;
							paddr <= {j.idx, 2'b00};
							pwdata <= j.value;
							gap_left = next_gap();
						end
					end else begin
						void'(work_list.pop_front());
						drv_word = j;
						nx_start = 1'b1;
						mean_a <= j.mean[0];
						mean_b <= j.mean[1];
						mean_c <= j.mean[2];
						mean_d <= j.mean[3];
						var_a <= j.dev[0];
						var_b <= j.dev[1];
						var_c <= j.dev[2];
						var_d <= j.dev[3];
						var_present <= j.vp;
						objective_count <= j.cnt;
						gap_left = next_gap();
					end
				end
			end
		end
		start <= nx_start;
		psel <= nx_sel;
		penable <= nx_en;
	end

	// The monitor samples on the rising edge. First it checks any result word
	// against the oldest expectation. Then it records register writes and the
	// words that were taken at this edge.
	always @(posedge clk) begin : watch_ports
		word_score_t want;
		word_taken = arst_n && start && !busy;
		reg_taken = arst_n && psel && penable && pwrite && pready;
		if (arst_n && done) begin
			if (pending_scores.size() == 0) begin
				$error("result word with no word outstanding");
				errors++;
			end else begin
				want = pending_scores.pop_front();
				if (score !== want.score) begin
					$error("score: expected %0d, got %0d", want.score, score);
					errors++;
				end
				if (score_var !== want.svar) begin
					$error("score_var: expected %0d, got %0d", want.svar, score_var);
					errors++;
				end
				if (score_sign !== want.sign) begin
					$error("score_sign: expected %0d, got %0d", want.sign, score_sign);
					errors++;
				end
			end
		end
		if (reg_taken) begin
			case (paddr[4:2])
				mos_pkg::REG_MODE: cfg_mode = mos_pkg::mode_t'(pwdata[1:0]);
				mos_pkg::REG_REF: cfg_ref = pwdata;
				mos_pkg::REG_AUG: cfg_alpha = pwdata[15:0];
				mos_pkg::REG_W_A: cfg_w[0] = pwdata[15:0];
				mos_pkg::REG_W_B: cfg_w[1] = pwdata[15:0];
				mos_pkg::REG_W_C: cfg_w[2] = pwdata[15:0];
				mos_pkg::REG_W_D: cfg_w[3] = pwdata[15:0];
				default: ;
			endcase
		end
		if (word_taken) pending_scores.push_back(scalarize_word(drv_word));
	end

	task automatic add_reg(logic [2:0] idx, logic [31:0] value);
		job_t j;
		j = '0;
		j.is_reg = 1'b1;
		j.idx = idx;
		j.value = value;
		work_list.push_back(j);
	endtask

	// Means and deviations are packed with objective a in the lowest slot.
	task automatic add_word(logic [3:0][31:0] m, logic [3:0][15:0] v, logic vp,
			logic [2:0] n);
		job_t j;
		j = '0;
		j.mean = m;
		j.dev = v;
		j.vp = vp;
		j.cnt = n;
		work_list.push_back(j);
	endtask

	// Means lean toward the extremes and toward the reference point. The
	// reference point gives zero deviations, and points near it give both signs.
	function automatic logic [31:0] pick_mean(logic [31:0] refv);
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return refv;
			3, 4: return refv + {{12{r[19]}}, r[19:0]};
			default: return r;
		endcase
	endfunction

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'd16384;
			3: return 16'd1;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_ref();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3, 4: return {{8{r[23]}}, r[23:0]};
			default: return r;
		endcase
	endfunction

	task automatic add_random_word(logic [31:0] refv);
		logic [3:0][31:0] m;
		logic [3:0][15:0] v;
		logic [2:0] n;
		int k;
		for (k = 0; k < 4; k++) begin
			m[k] = pick_mean(refv);
			case ($urandom_range(0, 7))
				0: v[k] = 16'h0;
				1: v[k] = 16'hFFFF;
				default: v[k] = 16'($urandom);
			endcase
		end
		// Equal means make ties common, which tests the first-minimum rule.
		if ($urandom_range(0, 9) == 0) m = {4{m[0]}};
		n = ($urandom_range(0, 9) < 6) ? 3'd4 : 3'($urandom_range(0, 7));
		add_word(m, v, $urandom_range(0, 4) != 0, n);
	endtask

	// This is the watchdog. A hung block or a lost handshake ends the run here.
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_multiobjective_scalarisation NOT OK");
		$finish;
	end

	initial begin : run
		int ph, k;
		logic [31:0] refv;
		logic [1:0] md;

		// The directed words below run under the reset registers first:
		// linear mode, unit quarter weights, reference zero and no augmentation.
		add_word('0, '0, 1'b1, 3'd4);
		add_word({4{32'h7FFF_FFFF}}, {4{16'hFFFF}}, 1'b1, 3'd4);
		add_word({4{32'h8000_0000}}, {4{16'hFFFF}}, 1'b1, 3'd4);
		// Variances absent: the deviation terms must not count.
		add_word({4{32'h7FFF_FFFF}}, {4{16'hFFFF}}, 1'b0, 3'd4);
		// No objectives: a zero result word must still come out.
		add_word({4{32'h1234_5678}}, {4{16'h00FF}}, 1'b1, 3'd0);
		// A count above the number of objectives is taken as all of them.
		add_word({32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h8000_0001},
			{16'h0100, 16'h0200, 16'h8000, 16'h0001}, 1'b1, 3'd7);
		add_word({32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h8000_0001},
			{16'h0100, 16'h0200, 16'h8000, 16'h0001}, 1'b1, 3'd5);
		add_word({32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001},
			{16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000}, 1'b1, 3'd1);
		add_word({32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001},
			{16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000}, 1'b1, 3'd2);
		add_word({32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001},
			{16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000}, 1'b1, 3'd3);

		// A write to an address that decodes to no register must change nothing.
		add_reg(REG_NONE, 32'hDEAD_BEEF);
		add_reg(mos_pkg::REG_MODE, mos_pkg::MODE_CHEB);
		add_reg(mos_pkg::REG_REF, 32'h8000_0000);
		add_reg(mos_pkg::REG_AUG, 32'h0000_FFFF);
		add_reg(mos_pkg::REG_W_A, 32'h0);
		add_reg(mos_pkg::REG_W_B, 32'h0000_FFFF);
		add_reg(mos_pkg::REG_W_C, 32'h1);
		add_reg(mos_pkg::REG_W_D, 32'h0000_FFFF);
		add_word({4{32'h7FFF_FFFF}}, {4{16'hFFFF}}, 1'b1, 3'd4);
		add_word({4{32'h8000_0000}}, {16'h0004, 16'h0003, 16'h0002, 16'h0001},
			1'b1, 3'd4);
		add_word({32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
			{16'h1111, 16'h2222, 16'h3333, 16'h4444}, 1'b1, 3'd4);

		// Augmented Chebyshev with the reference point at its top.
		add_reg(mos_pkg::REG_MODE, mos_pkg::MODE_AUG_CHEB);
		add_reg(mos_pkg::REG_REF, 32'h7FFF_FFFF);
		add_word({4{32'h8000_0000}}, {4{16'hFFFF}}, 1'b1, 3'd4);
		add_word({4{32'h0000_0000}}, {16'h0004, 16'h0003, 16'h0002, 16'h0001},
			1'b1, 3'd4);
		add_word({4{32'h8000_0000}}, {4{16'hFFFF}}, 1'b1, 3'd0);

		// Modified Chebyshev with the reference point back at zero.
		add_reg(mos_pkg::REG_MODE, mos_pkg::MODE_MOD_CHEB);
		add_reg(mos_pkg::REG_REF, 32'h0);
		add_word({32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000, 32'hFFFF_0000},
			{16'h0100, 16'h0200, 16'h0300, 16'h0400}, 1'b1, 3'd4);
		add_word({4{32'h0000_0000}}, {16'h0004, 16'h0003, 16'h0002, 16'h0001},
			1'b1, 3'd4);
		add_word({4{32'h7FFF_FFFF}}, {4{16'hFFFF}}, 1'b1, 3'd4);
		add_word({32'h0, 32'h0, 32'h0, 32'h8000_0000}, {4{16'hFFFF}}, 1'b0, 3'd1);

		// In the random phases the mode steps through all four values. The
		// other registers are rewritten at random, and their upper data bits
		// carry noise that the block must ignore.
		refv = 32'h0;
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			md = 2'(ph);
			add_reg(mos_pkg::REG_MODE, ($urandom & 32'hFFFF_FFFC) | 32'(md));
			if ($urandom_range(0, 1) == 0) begin
				refv = pick_ref();
				add_reg(mos_pkg::REG_REF, refv);
			end
			if ($urandom_range(0, 1) == 0)
				add_reg(mos_pkg::REG_AUG, ($urandom & 32'hFFFF_0000) | 32'(pick_weight()));
			if ($urandom_range(0, 1) == 0)
				add_reg(mos_pkg::REG_W_A, ($urandom & 32'hFFFF_0000) | 32'(pick_weight()));
			if ($urandom_range(0, 1) == 0)
				add_reg(mos_pkg::REG_W_B, ($urandom & 32'hFFFF_0000) | 32'(pick_weight()));
			if ($urandom_range(0, 1) == 0)
				add_reg(mos_pkg::REG_W_C, ($urandom & 32'hFFFF_0000) | 32'(pick_weight()));
			if ($urandom_range(0, 1) == 0)
				add_reg(mos_pkg::REG_W_D, ($urandom & 32'hFFFF_0000) | 32'(pick_weight()));
			for (k = 0; k < WORDS_PER_PHASE; k++) add_random_word(refv);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every job to be taken and every result word to arrive.
		// Then wait through the drain time, so that any extra result word
		// would be seen.
		@(negedge clk);
		while (work_list.size() > 0 || start || psel || pending_scores.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("tb_multiobjective_scalarisation OK");
		end else begin
			$display("tb_multiobjective_scalarisation NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire
